>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the predictor RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on a given clock, off while the given reset is low.
`define ASSERT_AT(label, clk_sig, rst_n_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (prop)) \
		else $error(msg);

// Check a property on the module's clk and arst_n.
`define ASSERT_STD(label, prop, msg) \
	`ASSERT_AT(label, clk, arst_n, prop, msg)

`endif

>>> hdl/lhbp_pkg.sv
// ----------------------------------------------------------------------------
// lhbp_pkg
// Shared types, widths and helpers of the local history branch predictor.
// ----------------------------------------------------------------------------
`default_nettype none

package lhbp_pkg;

	// Fixed field widths
	localparam int ADDR_W = 16;
	localparam int CFG_W  = 7;
	localparam int TOT_W  = 32;
	localparam int HIST_W = 2;
	localparam int CTR_W  = 2;
	localparam int NUM_CTR = 1 << HIST_W;
	localparam int STEP_W = $clog2(ADDR_W);

	localparam logic [CFG_W-1:0] NUM_ENTRIES_RST = 7'd64;

	// One row of the predictor memory: local history and its four counters
	typedef logic [NUM_CTR-1:0][CTR_W-1:0] ctr_row_t;

	typedef struct packed {
		logic [HIST_W-1:0] hist;
		ctr_row_t          ctrs;
	} row_t;

	localparam int ROW_W = $bits(row_t);

	// Request into the remainder unit
	typedef struct packed {
		logic              start;
		logic [ADDR_W-1:0] dividend;
		logic [CFG_W-1:0]  divisor;
	} mod_req_t;

	// Status out of the remainder unit
	typedef struct packed {
		logic busy;
		logic done;
	} mod_status_t;

	// Step a 2-bit counter toward the outcome, saturating at both ends
	function automatic logic [CTR_W-1:0] ctr_next(input logic [CTR_W-1:0] ctr,
	                                             input logic tk);
		logic [CTR_W-1:0] res;
		res = ctr;
		if (tk) begin
			if (ctr != '1)
				res = ctr + CTR_W'(1);
		end else begin
			if (ctr != '0)
				res = ctr - CTR_W'(1);
		end
		return res;
	endfunction

endpackage

`default_nettype wire

>>> hdl/lhbp_ram.sv
// ----------------------------------------------------------------------------
// lhbp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lhbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic                                  re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
	end

	// Registered read, hold data when not reading
	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

>>> hdl/lhbp_mod.sv
// ----------------------------------------------------------------------------
// lhbp_mod
// Bit-serial remainder unit: address modulo entry count, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lhbp_mod (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire lhbp_pkg::mod_req_t          req,
	output lhbp_pkg::mod_status_t            status,
	output logic [lhbp_pkg::CFG_W-1:0]       remainder
);
	import lhbp_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [ADDR_W-1:0] dvd_q;
	logic [CFG_W-1:0]  dsr_q;
	logic [CFG_W-1:0]  rem_q;

	logic [CFG_W:0]    r_ext;
	logic [CFG_W:0]    r_sub;
	logic [CFG_W-1:0]  rem_next;

	// Shift in the next dividend bit, subtract the divisor if it fits
	always_comb begin
		r_ext    = {rem_q, dvd_q[ADDR_W-1]};
		r_sub    = r_ext - {1'b0, dsr_q};
		rem_next = (r_ext >= {1'b0, dsr_q}) ? r_sub[CFG_W-1:0] : r_ext[CFG_W-1:0];
	end

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			// flag done for one cycle after the last step
			done_q <= busy_q && !req.start && (step_q == '0);
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(ADDR_W - 1);
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == '0)
					busy_q <= 1'b0;
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[ADDR_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign remainder   = rem_q;

	`ASSERT_STD(a_no_start_busy, req.start |-> !busy_q, "remainder unit restarted while busy")
	`ASSERT_STD(a_done_after_busy, done_q |-> $past(busy_q) && !busy_q,
		"remainder done without a finishing step")

endmodule

`default_nettype wire

>>> hdl/local_history_branch_predictor_unit.sv
// ----------------------------------------------------------------------------
// local_history_branch_predictor_unit
// Two-level local history branch predictor with 2-bit saturating counters.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+-------------------------------
//   in       | sink      | in_valid / in_stall     | instr_address, taken
//   out      | source    | out_valid / out_stall   | entry_index .. miss_total
//   cfg      | sink      | cfg_we (no wait)        | cfg_wdata (num_entries)
//
// Each word passes through the accepting cycle, 16 bit-serial remainder steps,
// one memory read and one write-back before the next word is accepted.
// Each entry is one memory row (history plus four counters), read and written
// once per word, so no forwarding is needed.
// After reset a clearing pass writes every row, with in_stall high.
// A stalled result waits in the output register; the next word is taken meanwhile
// and only its write-back waits for the output to drain.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module local_history_branch_predictor_unit #(
	parameter int MAX_ENTRIES = 64
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// configuration
	input  wire logic                                   cfg_we,
	input  wire logic [lhbp_pkg::CFG_W-1:0]             cfg_wdata,
	// input words
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic [lhbp_pkg::ADDR_W-1:0]            instr_address,
	input  wire logic                                   taken,
	// result words
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] entry_index,
	output logic [lhbp_pkg::HIST_W-1:0]                 history_used,
	output logic                                        prediction,
	output logic                                        mispredict,
	output logic [lhbp_pkg::TOT_W-1:0]                  prediction_total,
	output logic [lhbp_pkg::TOT_W-1:0]                  miss_total
);
	import lhbp_pkg::*;

	localparam int IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CFG_MAX = (1 << CFG_W) - 1;
	localparam logic [CFG_W-1:0] N_CAP =
		CFG_W'((MAX_ENTRIES > CFG_MAX) ? CFG_MAX : MAX_ENTRIES);
	localparam logic [IDX_W-1:0] LAST_ROW = IDX_W'(MAX_ENTRIES - 1);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_DIV,
		S_UPDATE
	} state_t;

	state_t             state_q;
	logic [IDX_W-1:0]   clr_q;
	logic [CFG_W-1:0]   num_entries_q;
	logic [CFG_W-1:0]   n_eff;

	logic [ADDR_W-1:0]  addr_q;
	logic               taken_q;
	logic [IDX_W-1:0]   idx_q;

	logic [TOT_W-1:0]   pred_cnt_q;
	logic [TOT_W-1:0]   miss_cnt_q;
	logic               out_valid_q;
	logic [IDX_W-1:0]   out_idx_q;
	logic [HIST_W-1:0]  out_hist_q;
	logic               out_pred_q;
	logic               out_miss_q;

	mod_req_t           div_req;
	mod_status_t        div_st;
	logic [CFG_W-1:0]   div_rem;

	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic [ROW_W-1:0]   ram_wdata;
	logic               ram_re;
	logic [IDX_W-1:0]   ram_raddr;
	logic [ROW_W-1:0]   ram_rdata;

	row_t               rd_row;
	row_t               new_row;
	logic [HIST_W-1:0]  hist;
	logic [CTR_W-1:0]   ctr;
	logic               pred;
	logic               miss;
	logic               accept;
	logic               upd_go;

	// Clamp the configured entry count to 1..MAX_ENTRIES
	always_comb begin
		n_eff = num_entries_q;
		if (num_entries_q == '0)
			n_eff = CFG_W'(1);
		else if (num_entries_q > N_CAP)
			n_eff = N_CAP;
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			num_entries_q <= NUM_ENTRIES_RST;
		else if (cfg_we)
			num_entries_q <= cfg_wdata;
	end

	// Remainder unit
	assign accept           = (state_q == S_IDLE) && in_valid;
	assign div_req.start    = accept;
	assign div_req.dividend = instr_address;
	assign div_req.divisor  = n_eff;

	lhbp_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (div_req),
		.status    (div_st),
		.remainder (div_rem)
	);

	// Predict from the row read back and build the updated row
	always_comb begin
		rd_row  = row_t'(ram_rdata);
		hist    = rd_row.hist;
		ctr     = rd_row.ctrs[hist];
		pred    = ctr[CTR_W-1];
		miss    = pred ^ taken_q;
		new_row = rd_row;
		new_row.ctrs[hist] = ctr_next(ctr, taken_q);
		new_row.hist       = {hist[HIST_W-2:0], taken_q};
	end

	// Memory access: clearing sweep or write-back, read when the index is known
	assign upd_go    = (state_q == S_UPDATE) && (!out_valid_q || !out_stall);
	assign ram_we    = (state_q == S_CLEAR) || upd_go;
	assign ram_waddr = (state_q == S_CLEAR) ? clr_q : idx_q;
	assign ram_wdata = (state_q == S_CLEAR) ? '0 : ROW_W'(new_row);
	assign ram_re    = (state_q == S_DIV) && div_st.done;
	assign ram_raddr = IDX_W'(div_rem);

	lhbp_ram #(
		.WIDTH (ROW_W),
		.DEPTH (MAX_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Sequencer, totals and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			addr_q      <= '0;
			taken_q     <= 1'b0;
			idx_q       <= '0;
			pred_cnt_q  <= '0;
			miss_cnt_q  <= '0;
			out_valid_q <= 1'b0;
			out_idx_q   <= '0;
			out_hist_q  <= '0;
			out_pred_q  <= 1'b0;
			out_miss_q  <= 1'b0;
		end else begin
			// load a new result at write-back, drop the result once taken
			if (upd_go)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == LAST_ROW)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						addr_q  <= instr_address;
						taken_q <= taken;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_st.done) begin
						idx_q   <= IDX_W'(div_rem);
						state_q <= S_UPDATE;
					end
				end
				S_UPDATE: begin
					if (upd_go) begin
						out_idx_q   <= idx_q;
						out_hist_q  <= hist;
						out_pred_q  <= pred;
						out_miss_q  <= miss;
						if (pred_cnt_q != '1)
							pred_cnt_q <= pred_cnt_q + TOT_W'(1);
						if (miss && (miss_cnt_q != '1))
							miss_cnt_q <= miss_cnt_q + TOT_W'(1);
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall         = (state_q != S_IDLE);
	assign out_valid        = out_valid_q;
	assign entry_index      = out_idx_q;
	assign history_used     = out_hist_q;
	assign prediction       = out_pred_q;
	assign mispredict       = out_miss_q;
	assign prediction_total = pred_cnt_q;
	assign miss_total       = miss_cnt_q;

	`ASSERT_STD(a_miss_le_pred, miss_cnt_q <= pred_cnt_q, "miss total above prediction total")
	`ASSERT_STD(a_done_in_div, div_st.done |-> (state_q == S_DIV),
		"remainder finished outside the divide state")
	`ASSERT_STD(a_update_loads_out, upd_go |=> out_valid_q,
		"write-back did not present a result")
	`ASSERT_STD(a_addr_held, (state_q == S_DIV) |=> $stable(addr_q),
		"captured address changed during the divide")

endmodule

`default_nettype wire

>>> tb/sv/tb_local_history_branch_predictor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_local_history_branch_predictor_unit
// Self-checking bench for the two-level local history branch predictor.
//
// A behavioral predictor tracks the per-entry history, the four 2-bit
// counters of each entry and both saturating totals. Every word the unit
// accepts is run through it, and each result word is checked field by field
// against the oldest prediction. Directed tests cover the address and
// entry-count extremes and counter saturation. Random traffic then runs
// under several entry counts with random idling on both channels, one long
// output hold-off and one full drain pause.
// ----------------------------------------------------------------------------

module tb_local_history_branch_predictor_unit;
	import lhbp_pkg::*;

	localparam int MAX_ENTRIES = 64;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE      = 4;
	localparam int TAIL_CYCLES = 40;

	typedef struct {
		logic [IDX_W-1:0]  entry_index;
		logic [HIST_W-1:0] history_used;
		logic              prediction;
		logic              mispredict;
		logic [TOT_W-1:0]  prediction_total;
		logic [TOT_W-1:0]  miss_total;
	} bp_result_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic              cfg_we        = 1'b0;
	logic [CFG_W-1:0]  cfg_wdata     = '0;
	logic              in_valid      = 1'b0;
	logic              in_stall;
	logic [ADDR_W-1:0] instr_address = '0;
	logic              taken         = 1'b0;
	logic              out_valid;
	logic              out_stall     = 1'b0;
	logic [IDX_W-1:0]  entry_index;
	logic [HIST_W-1:0] history_used;
	logic              prediction;
	logic              mispredict;
	logic [TOT_W-1:0]  prediction_total;
	logic [TOT_W-1:0]  miss_total;

	// Predictor state mirrored by the bench
	logic [CFG_W-1:0]  num_entries_cfg;
	logic [HIST_W-1:0] hist_tbl [MAX_ENTRIES];
	logic [CTR_W-1:0]  ctr_tbl  [MAX_ENTRIES][NUM_CTR];
	logic [TOT_W-1:0]  predict_cnt;
	logic [TOT_W-1:0]  miss_cnt;

	bp_result_t pending_predictions [$];
	int         mismatch_count = 0;

	// Idling knobs, percent chance of a gap or a stall
	int gap_pct   = 0;
	int stall_pct = 0;
	int hold_req  = 0;

	local_history_branch_predictor_unit #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.instr_address   (instr_address),
		.taken           (taken),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.entry_index     (entry_index),
		.history_used    (history_used),
		.prediction      (prediction),
		.mispredict      (mispredict),
		.prediction_total(prediction_total),
		.miss_total      (miss_total)
	);

	always #4 clk = ~clk;

	// Look up the entry, predict, then train counter, history and totals
	function automatic bp_result_t predict_and_train(input logic [ADDR_W-1:0] addr,
	                                                 input logic tk);
		int               n;
		int               idx;
		logic [HIST_W-1:0] h;
		logic [CTR_W-1:0]  c;
		bp_result_t        r;
		n = num_entries_cfg;
		if (n == 0)
			n = 1;
		if (n > MAX_ENTRIES)
			n = MAX_ENTRIES;
		idx = int'(addr) % n;
		h = hist_tbl[idx];
		c = ctr_tbl[idx][h];
		r.entry_index  = IDX_W'(idx);
		r.history_used = h;
		r.prediction   = (c >= 2'd2);
		r.mispredict   = (r.prediction != tk);
		if (predict_cnt != '1)
			predict_cnt = predict_cnt + 1'b1;
		if (r.mispredict && miss_cnt != '1)
			miss_cnt = miss_cnt + 1'b1;
		r.prediction_total = predict_cnt;
		r.miss_total       = miss_cnt;
		if (tk && c != 2'd3)
			c = c + 1'b1;
		else if (!tk && c != 2'd0)
			c = c - 1'b1;
		ctr_tbl[idx][h] = c;
		hist_tbl[idx]   = {h[0], tk};
		return r;
	endfunction

	function automatic int pick_gap();
		if ($urandom_range(0, 99) >= gap_pct)
			return 0;
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(20, 60);
		return $urandom_range(1, 3);
	endfunction

	task automatic report_mismatch(input string what, input logic [TOT_W-1:0] got,
	                               input logic [TOT_W-1:0] want);
		$display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h",
		         $time, what, got, want);
		mismatch_count++;
	endtask

	// Offer one word, hold it until accepted, then maybe idle
	task automatic send_word(input logic [ADDR_W-1:0] addr, input logic tk);
		int g;
		in_valid      <= 1'b1;
		instr_address <= addr;
		taken         <= tk;
		do
			@(posedge clk);
		while (in_stall);
		pending_predictions.insert(pending_predictions.size(), predict_and_train(addr, tk));
		g = pick_gap();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// Stop offering and wait until every predicted word has come back
	task automatic wait_drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_predictions.size() != 0)
			@(posedge clk);
	endtask

	// Write the entry count only while the unit is idle
	task automatic write_num_entries(input logic [CFG_W-1:0] value);
		wait_drain();
		repeat (SETTLE) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		num_entries_cfg = value;
	endtask

	// Stall the result channel: long hold-off on request, else random
	always @(posedge clk) begin
		int hold_seen;
		int hold_left;
		int stall_left;
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 99) < stall_pct) begin
			stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
			                                         : $urandom_range(0, 2);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Check each accepted result word against the oldest prediction
	always @(posedge clk) begin
		bp_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_predictions.size() == 0) begin
				report_mismatch("unexpected result word", '0, '0);
			end else begin
				want = pending_predictions.pop_front();
				if (entry_index !== want.entry_index)
					report_mismatch("entry_index", entry_index, want.entry_index);
				if (history_used !== want.history_used)
					report_mismatch("history_used", history_used, want.history_used);
				if (prediction !== want.prediction)
					report_mismatch("prediction", prediction, want.prediction);
				if (mispredict !== want.mispredict)
					report_mismatch("mispredict", mispredict, want.mispredict);
				if (prediction_total !== want.prediction_total)
					report_mismatch("prediction_total", prediction_total,
					                want.prediction_total);
				if (miss_total !== want.miss_total)
					report_mismatch("miss_total", miss_total, want.miss_total);
			end
		end
	end

	// Reset entry count, address extremes on both ends of the table
	task automatic test_reset_defaults();
		send_word(16'h0000, 1'b0);
		send_word(16'hFFFF, 1'b1);
		send_word(16'h0040, 1'b1);
		send_word(16'h003F, 1'b0);
	endtask

	// Zero entry count folds every address onto entry 0
	task automatic test_zero_entries();
		write_num_entries(7'd0);
		send_word(16'hFFFF, 1'b1);
		send_word(16'h1234, 1'b0);
	endtask

	// Entry counts above the table size clamp to the table size
	task automatic test_oversized_entries();
		write_num_entries(7'h7F);
		send_word(16'hFFFF, 1'b1);
		send_word(16'h8000, 1'b1);
		write_num_entries(7'd65);
		send_word(16'hFFBF, 1'b0);
	endtask

	// Drive one entry to both counter limits through all four histories
	task automatic test_counter_saturation();
		write_num_entries(7'd64);
		repeat (6) send_word(16'h0005, 1'b1);
		repeat (6) send_word(16'h0005, 1'b0);
	endtask

	// Mostly recurring branches with fixed outcome patterns, some noise
	task automatic run_branch_mix(input int count);
		logic [ADDR_W-1:0] ws_addr [4];
		logic [7:0]        ws_pat  [4];
		int                ws_len  [4];
		int                ws_pos  [4];
		int                k;
		logic              tk;
		for (int i = 0; i < 4; i++) begin
			ws_addr[i] = ADDR_W'($urandom);
			ws_pat[i]  = 8'($urandom);
			ws_len[i]  = $urandom_range(1, 8);
			ws_pos[i]  = 0;
		end
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < 80) begin
				k  = $urandom_range(0, 3);
				tk = ws_pat[k][ws_pos[k] % ws_len[k]];
				ws_pos[k]++;
				if ($urandom_range(0, 19) == 0)
					tk = ~tk;
				send_word(ws_addr[k], tk);
			end else begin
				send_word(ADDR_W'($urandom), 1'($urandom));
			end
		end
	endtask

	// Random traffic under a range of entry counts and idling levels
	task automatic test_random_traffic();
		logic [CFG_W-1:0] settings [8];
		settings = '{7'd64, 7'd13, 7'd1, 7'd0, 7'h7F, 7'd65,
		             CFG_W'($urandom_range(2, 63)), CFG_W'($urandom_range(1, 127))};
		foreach (settings[p]) begin
			write_num_entries(settings[p]);
			gap_pct   = (p == 0) ? 0 : $urandom_range(10, 50);
			stall_pct <= (p == 0) ? 0 : $urandom_range(10, 50);
			run_branch_mix(100);
		end
	endtask

	// Hold the result channel off while words keep coming
	task automatic test_output_backpressure();
		write_num_entries(7'd16);
		gap_pct = 0;
		stall_pct <= 0;
		hold_req <= hold_req + 1;
		run_branch_mix(40);
	endtask

	// Pause the sender until the unit is empty, then resume
	task automatic test_sender_pause();
		gap_pct = 20;
		stall_pct <= 20;
		run_branch_mix(10);
		wait_drain();
		run_branch_mix(10);
	endtask

	initial begin
		num_entries_cfg = NUM_ENTRIES_RST;
		predict_cnt     = '0;
		miss_cnt        = '0;
		foreach (hist_tbl[i]) begin
			hist_tbl[i] = '0;
			for (int j = 0; j < NUM_CTR; j++)
				ctr_tbl[i][j] = '0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_zero_entries();
		test_oversized_entries();
		test_counter_saturation();
		test_random_traffic();
		test_output_backpressure();
		test_sender_pause();

		// Drain, then watch for stray result words
		wait_drain();
		stall_pct <= 0;
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("** local_history_branch_predictor_unit: PASSED **");
		else
			$display("** local_history_branch_predictor_unit: FAILED **");
		$finish;
	end

	initial begin
		#5000000;
		$display("%0t ns: timeout with %0d result words outstanding",
		         $time, pending_predictions.size());
		$display("** local_history_branch_predictor_unit: FAILED **");
		$finish;
	end

endmodule

>>> sim.f
+incdir+hdl
hdl/lhbp_pkg.sv
hdl/lhbp_ram.sv
hdl/lhbp_mod.sv
hdl/local_history_branch_predictor_unit.sv
tb/sv/tb_local_history_branch_predictor_unit.sv
